// ----- rtl/kalman_angle_gyro_fusion_assert.svh -----
// ----------------------------------------------------------------------------
// kalman angle fusion assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_GYRO_FUSION_ASSERT_SVH
`define KALMAN_ANGLE_GYRO_FUSION_ASSERT_SVH
`ifndef SYNTHESIS
`define KAGF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KAGF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KAGF_ASSERT_SAME(lbl, ante, cons)
`define KAGF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/kagf_pkg.sv -----
// ----------------------------------------------------------------------------
// kagf package
// shared types and constants of the kalman angle fusion block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kagf_pkg;
	localparam int FRAC = 24;
	localparam int CHUNK = 16;

	typedef enum logic [0:0] {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_e_t;

	typedef struct packed {
		logic      start;
		alu_op_e_t op;
	} alu_req_t;

	typedef enum logic [2:0] {
		REG_TIME_STEP   = 3'd0,
		REG_ANGLE_NOISE = 3'd1,
		REG_BIAS_NOISE  = 3'd2,
		REG_MEAS_NOISE  = 3'd3,
		REG_OBS_GAIN    = 3'd4
	} reg_idx_e_t;

	typedef enum logic [3:0] {
		STEP_ANGLE_PRED = 4'd0,
		STEP_P00_PRED   = 4'd1,
		STEP_P01_PRED   = 4'd2,
		STEP_P11_PRED   = 4'd3,
		STEP_PCT0       = 4'd4,
		STEP_PCT1       = 4'd5,
		STEP_INNOV_VAR  = 4'd6,
		STEP_GAIN0      = 4'd7,
		STEP_GAIN1      = 4'd8,
		STEP_T1         = 4'd9,
		STEP_P00_CORR   = 4'd10,
		STEP_P01_CORR   = 4'd11,
		STEP_P10_CORR   = 4'd12,
		STEP_P11_CORR   = 4'd13,
		STEP_ANGLE_CORR = 4'd14,
		STEP_BIAS_CORR  = 4'd15
	} step_e_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_e_t;
endpackage
`default_nettype wire

// ----- rtl/kagf_cfg.sv -----
// ----------------------------------------------------------------------------
// kagf configuration registers
// holds time step, noise terms and observation gain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kagf_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic [24:0]             time_step,
	output logic [30:0]             angle_process_noise,
	output logic [30:0]             bias_process_noise,
	output logic [30:0]             measure_noise,
	output logic signed [31:0]      observe_gain
);
	logic [24:0]        dt_q;
	logic [30:0]        qa_q, qg_q, rm_q;
	logic signed [31:0] c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 25'd16777;
			qa_q <= 31'd16777;
			qg_q <= 31'd83886;
			rm_q <= 31'd8388608;
			c_q  <= 32'sd16777216;
		end else if (cfg_valid) begin
			unique case (kagf_pkg::reg_idx_e_t'(cfg_index))
				kagf_pkg::REG_TIME_STEP:   dt_q <= cfg_data[24:0];
				kagf_pkg::REG_ANGLE_NOISE: qa_q <= cfg_data[30:0];
				kagf_pkg::REG_BIAS_NOISE:  qg_q <= cfg_data[30:0];
				kagf_pkg::REG_MEAS_NOISE:  rm_q <= cfg_data[30:0];
				kagf_pkg::REG_OBS_GAIN:    c_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign time_step           = dt_q;
	assign angle_process_noise = qa_q;
	assign bias_process_noise  = qg_q;
	assign measure_noise       = rm_q;
	assign observe_gain        = c_q;
endmodule
`default_nettype wire

// ----- rtl/kagf_alu.sv -----
// ----------------------------------------------------------------------------
// kagf shared multiply / divide unit
// q.24 rounded multiply by 16-bit chunks, restoring q.24 divide one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kagf_alu #(
	parameter int W  = 32,
	parameter int OW = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire kagf_pkg::alu_req_t     req,
	input  wire logic signed [OW-1:0]   a,
	input  wire logic signed [OW-1:0]   b,
	output logic                        done,
	output logic signed [W-1:0]         res
);
	localparam int NCH = (OW + kagf_pkg::CHUNK - 1) / kagf_pkg::CHUNK;
	localparam int YW  = NCH * kagf_pkg::CHUNK;
	localparam int PW  = YW + OW;
	localparam int NW  = OW + kagf_pkg::FRAC;
	localparam int MW  = PW + 1;
	localparam int CW  = $clog2(NW + 1);

	logic                    busy_q, done_q, neg_q;
	kagf_pkg::alu_op_e_t     op_q;
	logic [OW-1:0]           x_q;
	logic [YW-1:0]           y_q;
	logic [PW-1:0]           acc_q;
	logic [NW-1:0]           num_q, quo_q;
	logic [OW:0]             rem_q;
	logic [CW-1:0]           cnt_q;
	logic signed [W-1:0]     res_q;

	logic [OW-1:0]           mag_a, mag_b;
	logic [OW+kagf_pkg::CHUNK-1:0] part;
	logic [OW:0]             rem2;
	logic                    ge;
	logic [MW-1:0]           rnd, mag_r, lim;
	logic signed [W-1:0]     sat_r;

	assign mag_a = a[OW-1] ? OW'(-a) : OW'(a);
	assign mag_b = b[OW-1] ? OW'(-b) : OW'(b);
	assign part  = x_q * y_q[YW-1 -: kagf_pkg::CHUNK];
	assign rem2  = {rem_q[OW-1:0], num_q[NW-1]};
	assign ge    = rem2 >= {1'b0, x_q};
	assign rnd   = MW'(acc_q) + (MW'(1) << (kagf_pkg::FRAC - 1));
	assign lim   = MW'(1) << (W - 1);

	always_comb begin
		if (op_q == kagf_pkg::ALU_MUL) mag_r = rnd >> kagf_pkg::FRAC;
		else mag_r = MW'(quo_q);
		if (neg_q) begin
			if (mag_r > lim) sat_r = W'(-lim);
			else sat_r = W'(-mag_r);
		end else begin
			if (mag_r > lim - MW'(1)) sat_r = W'(lim - MW'(1));
			else sat_r = W'(mag_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == kagf_pkg::ALU_MUL) ? CW'(NCH) : CW'(NW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			op_q <= req.op;
			if (req.op == kagf_pkg::ALU_MUL) begin
				neg_q <= a[OW-1] ^ b[OW-1];
				x_q   <= mag_a;
				y_q   <= YW'(mag_b);
				acc_q <= '0;
			end else begin
				// divisor is positive here, held in x
				neg_q <= a[OW-1];
				x_q   <= OW'(b);
				num_q <= {mag_a, {kagf_pkg::FRAC{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				res_q <= sat_r;
			end else if (op_q == kagf_pkg::ALU_MUL) begin
				acc_q <= (acc_q << kagf_pkg::CHUNK) + PW'(part);
				y_q   <= y_q << kagf_pkg::CHUNK;
			end else begin
				rem_q <= ge ? rem2 - {1'b0, x_q} : rem2;
				quo_q <= {quo_q[NW-2:0], ge};
				num_q <= num_q << 1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

// ----- rtl/kalman_angle_gyro_fusion.sv -----
// ----------------------------------------------------------------------------
// kalman angle / gyro bias fusion
// two-state kalman filter sequenced over one shared multiply / divide unit
// ----------------------------------------------------------------------------
// each input transaction runs through the prediction, gain and correction steps on the
//   shared unit before output valid; the two divisions dominate the run time
// a new input is accepted only after the output has been taken, so output stalls hold it off;
//   a non-positive innovation variance skips both divisions
// reset clears angle, bias and covariance to zero and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_angle_gyro_fusion_assert.svh"
module kalman_angle_gyro_fusion #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [63:0]    s_tdata,   // angle_meas, gyro_meas
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [63:0]         m_tdata,   // angle_est, rate_est
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);
	localparam int W  = WORD_WIDTH;
	localparam int OW = (W > 32) ? W : 32;
	localparam int XW = OW + 2;
	localparam logic signed [XW-1:0] WMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] WMIN = ~WMAX;
	localparam logic signed [XW-1:0] OMAX = {{(XW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XW-1:0] OMIN = ~OMAX;

	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
		if (x > WMAX) return WMAX[W-1:0];
		else if (x < WMIN) return WMIN[W-1:0];
		else return x[W-1:0];
	endfunction

	function automatic logic [31:0] sat_o(input logic signed [XW-1:0] x);
		if (x > OMAX) return OMAX[31:0];
		else if (x < OMIN) return OMIN[31:0];
		else return x[31:0];
	endfunction

	function automatic logic signed [XW-1:0] xw(input logic signed [W-1:0] v);
		return XW'(v);
	endfunction

	logic [24:0]          dt;
	logic [30:0]          qa, qg, rm;
	logic signed [31:0]   cg;

	kagf_pkg::state_e_t   state_q;
	kagf_pkg::step_e_t    step_q;
	logic                 issued_q;
	logic signed [W-1:0]  ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0]  t0_q, pct1_q, t1_q, k0_q, k1_q, e_q, err_q;
	logic signed [31:0]   am_q, gm_q;
	logic [31:0]          out_ang_q, out_rate_q;

	kagf_pkg::alu_req_t   req;
	logic signed [OW-1:0] op_a, op_b;
	logic                 alu_done;
	logic signed [W-1:0]  m;
	logic signed [W-1:0]  pd0, pd1, gmb;
	logic                 e_pos, skip_div;
	logic signed [OW-1:0] dt_o;

	kagf_cfg u_cfg (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.time_step           (dt),
		.angle_process_noise (qa),
		.bias_process_noise  (qg),
		.measure_noise       (rm),
		.observe_gain        (cg)
	);

	kagf_alu #(.W(W), .OW(OW)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (op_a),
		.b      (op_b),
		.done   (alu_done),
		.res    (m)
	);

	assign dt_o     = $signed({{(OW-25){1'b0}}, dt});
	assign gmb      = sat_w(XW'(gm_q) - xw(bias_q));
	assign pd0      = sat_w(xw(sat_w($signed({{(XW-31){1'b0}}, qa}) - xw(p01_q))) - xw(p10_q));
	assign pd1      = sat_w(-xw(p11_q));
	assign e_pos    = !e_q[W-1] && (e_q != '0);
	assign skip_div = (step_q == kagf_pkg::STEP_GAIN0) && !e_pos;

	always_comb begin
		req.op = kagf_pkg::ALU_MUL;
		op_a   = OW'(pd1);
		op_b   = dt_o;
		unique case (step_q)
			kagf_pkg::STEP_ANGLE_PRED: op_a = OW'(gmb);
			kagf_pkg::STEP_P00_PRED:   op_a = OW'(pd0);
			kagf_pkg::STEP_P01_PRED:   op_a = OW'(pd1);
			kagf_pkg::STEP_P11_PRED:   op_a = $signed({{(OW-31){1'b0}}, qg});
			kagf_pkg::STEP_PCT0: begin
				op_a = OW'(cg); op_b = OW'(p00_q);
			end
			kagf_pkg::STEP_PCT1: begin
				op_a = OW'(cg); op_b = OW'(p10_q);
			end
			kagf_pkg::STEP_INNOV_VAR: begin
				op_a = OW'(cg); op_b = OW'(t0_q);
			end
			kagf_pkg::STEP_GAIN0: begin
				req.op = kagf_pkg::ALU_DIV; op_a = OW'(t0_q); op_b = OW'(e_q);
			end
			kagf_pkg::STEP_GAIN1: begin
				req.op = kagf_pkg::ALU_DIV; op_a = OW'(pct1_q); op_b = OW'(e_q);
			end
			kagf_pkg::STEP_T1: begin
				op_a = OW'(cg); op_b = OW'(p01_q);
			end
			kagf_pkg::STEP_P00_CORR: begin
				op_a = OW'(k0_q); op_b = OW'(t0_q);
			end
			kagf_pkg::STEP_P01_CORR: begin
				op_a = OW'(k0_q); op_b = OW'(t1_q);
			end
			kagf_pkg::STEP_P10_CORR: begin
				op_a = OW'(k1_q); op_b = OW'(t0_q);
			end
			kagf_pkg::STEP_P11_CORR: begin
				op_a = OW'(k1_q); op_b = OW'(t1_q);
			end
			kagf_pkg::STEP_ANGLE_CORR: begin
				op_a = OW'(k0_q); op_b = OW'(err_q);
			end
			kagf_pkg::STEP_BIAS_CORR: begin
				op_a = OW'(k1_q); op_b = OW'(err_q);
			end
			default: ;
		endcase
		req.start = (state_q == kagf_pkg::ST_RUN) && !issued_q && !skip_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kagf_pkg::ST_IDLE;
			step_q   <= kagf_pkg::STEP_ANGLE_PRED;
			issued_q <= 1'b0;
			ang_q    <= '0;
			bias_q   <= '0;
			p00_q    <= '0;
			p01_q    <= '0;
			p10_q    <= '0;
			p11_q    <= '0;
		end else begin
			unique case (state_q)
				kagf_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= kagf_pkg::ST_RUN;
						step_q  <= kagf_pkg::STEP_ANGLE_PRED;
					end
				end
				kagf_pkg::ST_RUN: begin
					if (skip_div) begin
						// no correction when innovation variance is not positive
						step_q <= kagf_pkg::STEP_T1;
					end else if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (alu_done) begin
						issued_q <= 1'b0;
						step_q   <= kagf_pkg::step_e_t'(step_q + 4'd1);
						unique case (step_q)
							kagf_pkg::STEP_ANGLE_PRED: ang_q <= sat_w(xw(ang_q) + xw(m));
							kagf_pkg::STEP_P00_PRED:   p00_q <= sat_w(xw(p00_q) + xw(m));
							kagf_pkg::STEP_P01_PRED: begin
								p01_q <= sat_w(xw(p01_q) + xw(m));
								p10_q <= sat_w(xw(p10_q) + xw(m));
							end
							kagf_pkg::STEP_P11_PRED:   p11_q <= sat_w(xw(p11_q) + xw(m));
							kagf_pkg::STEP_P00_CORR:   p00_q <= sat_w(xw(p00_q) - xw(m));
							kagf_pkg::STEP_P01_CORR:   p01_q <= sat_w(xw(p01_q) - xw(m));
							kagf_pkg::STEP_P10_CORR:   p10_q <= sat_w(xw(p10_q) - xw(m));
							kagf_pkg::STEP_P11_CORR:   p11_q <= sat_w(xw(p11_q) - xw(m));
							kagf_pkg::STEP_ANGLE_CORR: ang_q <= sat_w(xw(ang_q) + xw(m));
							kagf_pkg::STEP_BIAS_CORR: begin
								bias_q  <= sat_w(xw(bias_q) + xw(m));
								state_q <= kagf_pkg::ST_OUT;
							end
							default: ;
						endcase
					end
				end
				kagf_pkg::ST_OUT: begin
					if (m_tready) state_q <= kagf_pkg::ST_IDLE;
				end
				default: state_q <= kagf_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == kagf_pkg::ST_IDLE && s_tvalid) begin
			am_q <= $signed(s_tdata[31:0]);
			gm_q <= $signed(s_tdata[63:32]);
		end
		if (skip_div) begin
			k0_q <= '0;
			k1_q <= '0;
		end else if (state_q == kagf_pkg::ST_RUN && issued_q && alu_done) begin
			case (step_q)
				kagf_pkg::STEP_PCT0: begin
					t0_q  <= m;
					err_q <= sat_w(XW'(am_q) - xw(ang_q));
				end
				kagf_pkg::STEP_PCT1:      pct1_q <= m;
				kagf_pkg::STEP_INNOV_VAR: e_q <= sat_w($signed({{(XW-31){1'b0}}, rm}) + xw(m));
				kagf_pkg::STEP_GAIN0:     k0_q <= m;
				kagf_pkg::STEP_GAIN1:     k1_q <= m;
				kagf_pkg::STEP_T1:        t1_q <= m;
				kagf_pkg::STEP_BIAS_CORR: begin
					out_ang_q  <= sat_o(xw(ang_q));
					out_rate_q <= sat_o(XW'(gm_q) - xw(sat_w(xw(bias_q) + xw(m))));
				end
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == kagf_pkg::ST_IDLE);
	assign m_tvalid = (state_q == kagf_pkg::ST_OUT);
	assign m_tdata  = {out_rate_q, out_ang_q};

	`KAGF_ASSERT_SAME(a_one_side, s_tready, !m_tvalid)
	`KAGF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`KAGF_ASSERT_SAME(a_start_in_run, req.start, state_q == kagf_pkg::ST_RUN)
	`KAGF_ASSERT_NEXT(a_done_single, alu_done, !alu_done)
endmodule
`default_nettype wire
